// ----- design/isd_pkg.sv -----
// Shared types and constants for the id sized packet deframer.
// Used by isd_front, isd_queue, isd_back and the top level; depends on nothing.
package isd_pkg;

  // Number of id bits that index the size table; ids with higher bits set are unknown.
  localparam int ID_BITS     = 12;
  localparam int TABLE_DEPTH = 1 << ID_BITS;

  localparam int SIZE_W  = 15;
  localparam logic [SIZE_W-1:0] MAX_LEN = 15'h7FFF;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;

  // Operation codes carried on in_tuser.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_UNKNOWN = 2'd1;
  localparam logic [1:0] KIND_BADLEN  = 2'd2;

  // Size table codes.
  localparam logic [SIZE_W-1:0] SIZE_UNKNOWN  = 15'd0;
  localparam logic [SIZE_W-1:0] SIZE_VARIABLE = 15'd1;

  // One stream byte together with the size table word looked up for it.
  typedef struct packed {
    logic [7:0]        data_byte;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [3:0] {
    ST_ID0,
    ST_ID1,
    ST_LEN0,
    ST_LEN1,
    ST_BODY,
    ST_HDR_HI,
    ST_VLEN_B1,
    ST_VLEN_B2,
    ST_VLEN_B3,
    ST_REHDR
  } back_state_t;

endpackage

// ----- design/id_sized_packet_deframer.sv -----
// Top level of the id sized packet deframer: splits a byte stream into packets sized by id.
// Depends on isd_pkg, isd_front, isd_queue and isd_back.
//
// The in_ channel carries requests: in_tuser selects a stream byte or a size table write.
// Each packet opens with a little-endian 16-bit id looked up in the size table; a fixed
// entry gives the total length, a variable entry takes the length from the next two bytes.
// Packet bytes leave on the out_ channel as they arrive, marked first (tuser) and last
// (tlast); unknown ids and bad variable lengths leave as drop events instead.
// A body byte passes the table read at the accepting edge, then the queue write, then the
// output register, and waits in the queue while the back is busy. Throughput is one stream
// byte per cycle in packet bodies while out_tready stays high. The back takes each header
// byte from the queue in its own state and emits the remaining header bytes from stored
// fields in follow-up states; a bad length is reparsed as an id in ST_REHDR. The four-entry
// queue absorbs the bytes that arrive meanwhile; a run of short packets fills it and
// in_tready drops. Table writes give no result.
// After reset the block sweeps the 4096-entry size table to zero, one entry per cycle, and
// in_tready stays low until the sweep is done. When the receiver stalls, the output register
// holds its result, the queue fills, and in_tready drops once the queue has no room.
module id_sized_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // operation (0 stream byte, 1 table write)
  input  logic [39:0] in_tdata,   // data_byte[7:0], entry_index[19:8], entry_size[34:20]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_byte[7:0], packet_id[23:8], packet_length[39:24]
  output logic [2:0]  out_tuser,  // out_kind[1:0], out_first[2]
  output logic        out_tlast   // out_last
);

  logic                        q_push;
  isd_pkg::entry_t             q_push_data;
  logic                        q_pop;
  logic                        q_valid;
  isd_pkg::entry_t             q_data;
  logic [isd_pkg::Q_LVL_W-1:0] q_level;

  // Front: accepts requests, performs table writes and the lookup for each stream byte.
  isd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .q_push      (q_push),
    .q_push_data (q_push_data),
    .q_level     (q_level)
  );

  // Queue: decouples lookups from the multi-result header handling in the back.
  isd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .level     (q_level)
  );

  // Back: parses headers, tracks the packet body and drives the output register.
  isd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- design/isd_front.sv -----
// Front part of the deframer: accepts requests, owns the size table and clears it after reset.
// Depends on isd_pkg.
module isd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_tuser,
  input  logic [39:0]                in_tdata,
  output logic                       q_push,
  output isd_pkg::entry_t            q_push_data,
  input  logic [isd_pkg::Q_LVL_W-1:0] q_level
);

  logic [isd_pkg::SIZE_W-1:0]  size_mem [isd_pkg::TABLE_DEPTH];
  logic [isd_pkg::SIZE_W-1:0]  rd_data_r;
  logic                        clr_busy_r;
  logic [isd_pkg::ID_BITS-1:0] clr_addr_r;
  logic                        s1_valid_r;
  logic [7:0]                  s1_byte_r;
  logic [7:0]                  prev_byte_r;

  logic                        accept;
  logic                        is_byte;
  logic [7:0]                  in_byte;
  logic [15:0]                 wr_index16;
  logic [15:0]                 rd_id16;
  logic                        mem_we;
  logic [isd_pkg::ID_BITS-1:0] mem_waddr;
  logic [isd_pkg::SIZE_W-1:0]  mem_wdata;
  logic [isd_pkg::Q_LVL_W:0]   used;

  assign in_byte    = in_tdata[7:0];
  assign wr_index16 = {4'd0, in_tdata[19:8]};
  // A lookup is issued for every stream byte, keyed by this byte and the byte before it.
  // The back uses it only when the byte closes an id or a length field.
  assign rd_id16    = {in_byte, prev_byte_r};

  // Room is counted for the item sitting in the lookup stage as well.
  assign used      = {1'b0, q_level} + {{isd_pkg::Q_LVL_W{1'b0}}, s1_valid_r};
  assign in_tready = !clr_busy_r && (used < (isd_pkg::Q_LVL_W+1)'(isd_pkg::Q_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign is_byte   = (in_tuser == isd_pkg::OP_BYTE);

  always_comb begin
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = isd_pkg::SIZE_UNKNOWN;
    end else begin
      mem_we    = accept && (in_tuser == isd_pkg::OP_WRITE);
      mem_waddr = wr_index16[isd_pkg::ID_BITS-1:0];
      mem_wdata = in_tdata[34:20];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[mem_waddr] <= mem_wdata;
    end
    if (accept && is_byte) begin
      rd_data_r <= size_mem[rd_id16[isd_pkg::ID_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      s1_valid_r <= accept && is_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_byte) begin
      s1_byte_r   <= in_byte;
      prev_byte_r <= in_byte;
    end
  end

  assign q_push                = s1_valid_r;
  assign q_push_data.data_byte = s1_byte_r;
  assign q_push_data.size      = rd_data_r;

endmodule

// ----- design/isd_queue.sv -----
// Short queue of looked-up stream bytes between the front and the back.
// Depends on isd_pkg.
module isd_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  isd_pkg::entry_t             push_data,
  input  logic                        pop,
  output logic                        pop_valid,
  output isd_pkg::entry_t             pop_data,
  output logic [isd_pkg::Q_LVL_W-1:0] level
);

  isd_pkg::entry_t             slots_r [isd_pkg::Q_DEPTH];
  logic [isd_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [isd_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [isd_pkg::Q_LVL_W-1:0] level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

  assign pop_valid = (level_r != '0);
  assign pop_data  = slots_r[rd_ptr_r];
  assign level     = level_r;

  // The front reserves room before it accepts, so the queue never overflows.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r == isd_pkg::Q_LVL_W'(isd_pkg::Q_DEPTH)) |-> (!push || pop))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue popped while empty");

endmodule

// ----- design/isd_back.sv -----
// Back part of the deframer: header and body state machine and the output register.
// Depends on isd_pkg; takes looked-up bytes from isd_queue.
module isd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  isd_pkg::entry_t q_data,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [39:0]     out_tdata,
  output logic [2:0]      out_tuser,
  output logic            out_tlast
);

  isd_pkg::back_state_t       state_r, state_nxt;
  logic [15:0]                cur_id_r, cur_id_nxt;
  logic [7:0]                 id_lo_r, id_lo_nxt;
  logic [7:0]                 len_lo_r, len_lo_nxt;
  logic [15:0]                cur_len_r, cur_len_nxt;
  logic [isd_pkg::SIZE_W-1:0] rem_r, rem_nxt;
  logic [isd_pkg::SIZE_W-1:0] size_r, size_nxt;

  logic                       out_valid_r;
  logic [1:0]                 o_kind_r;
  logic [7:0]                 o_byte_r;
  logic                       o_first_r, o_last_r;
  logic [15:0]                o_id_r, o_len_r;

  logic                       can_emit;
  logic                       emit;
  logic [1:0]                 e_kind;
  logic [7:0]                 e_byte;
  logic                       e_first, e_last;
  logic [15:0]                e_id, e_len;

  logic [7:0]                 b;
  logic [15:0]                hdr_id;
  logic [isd_pkg::SIZE_W-1:0] hdr_size;
  logic                       hdr_oob;
  logic [isd_pkg::SIZE_W-1:0] hdr_eff;
  logic [15:0]                vlen;
  logic                       vlen_bad;

  assign can_emit = !out_valid_r || out_tready;
  assign b        = q_data.data_byte;

  // Header lookup is shared by a freshly received id and by a bad length reparsed as an id.
  assign hdr_id   = (state_r == isd_pkg::ST_REHDR) ? cur_id_r : {b, id_lo_r};
  assign hdr_size = (state_r == isd_pkg::ST_REHDR) ? size_r : q_data.size;
  assign hdr_oob  = (hdr_id >> isd_pkg::ID_BITS) != 16'd0;
  assign hdr_eff  = hdr_oob ? isd_pkg::SIZE_UNKNOWN : hdr_size;

  assign vlen     = {b, len_lo_r};
  assign vlen_bad = (vlen < 16'd4) || (vlen > {1'b0, isd_pkg::MAX_LEN});

  always_comb begin
    state_nxt   = state_r;
    cur_id_nxt  = cur_id_r;
    id_lo_nxt   = id_lo_r;
    len_lo_nxt  = len_lo_r;
    cur_len_nxt = cur_len_r;
    rem_nxt     = rem_r;
    size_nxt    = size_r;
    q_pop       = 1'b0;
    emit        = 1'b0;
    e_kind      = isd_pkg::KIND_BYTE;
    e_byte      = 8'd0;
    e_first     = 1'b0;
    e_last      = 1'b0;
    e_id        = cur_id_r;
    e_len       = cur_len_r;

    if (can_emit) begin
      unique case (state_r)
        isd_pkg::ST_ID1, isd_pkg::ST_REHDR: begin
          if (state_r == isd_pkg::ST_REHDR || q_valid) begin
            q_pop      = (state_r == isd_pkg::ST_ID1);
            cur_id_nxt = hdr_id;
            id_lo_nxt  = hdr_id[7:0];
            e_id       = hdr_id;
            if (hdr_eff == isd_pkg::SIZE_UNKNOWN) begin
              emit      = 1'b1;
              e_kind    = isd_pkg::KIND_UNKNOWN;
              e_len     = 16'd0;
              state_nxt = isd_pkg::ST_ID0;
            end else if (hdr_eff == isd_pkg::SIZE_VARIABLE) begin
              state_nxt = isd_pkg::ST_LEN0;
            end else begin
              emit        = 1'b1;
              e_byte      = hdr_id[7:0];
              e_first     = 1'b1;
              e_len       = {1'b0, hdr_eff};
              cur_len_nxt = {1'b0, hdr_eff};
              rem_nxt     = hdr_eff - isd_pkg::SIZE_W'(2);
              state_nxt   = isd_pkg::ST_HDR_HI;
            end
          end
        end
        isd_pkg::ST_HDR_HI: begin
          emit      = 1'b1;
          e_byte    = cur_id_r[15:8];
          e_last    = (rem_r == '0);
          state_nxt = (rem_r == '0) ? isd_pkg::ST_ID0 : isd_pkg::ST_BODY;
        end
        isd_pkg::ST_LEN0: begin
          if (q_valid) begin
            q_pop      = 1'b1;
            len_lo_nxt = b;
            state_nxt  = isd_pkg::ST_LEN1;
          end
        end
        isd_pkg::ST_LEN1: begin
          if (q_valid) begin
            q_pop = 1'b1;
            emit  = 1'b1;
            e_len = vlen;
            if (vlen_bad) begin
              // Drop the id and parse the two length bytes as the next id.
              e_kind     = isd_pkg::KIND_BADLEN;
              cur_id_nxt = vlen;
              size_nxt   = q_data.size;
              state_nxt  = isd_pkg::ST_REHDR;
            end else begin
              e_byte      = cur_id_r[7:0];
              e_first     = 1'b1;
              cur_len_nxt = vlen;
              rem_nxt     = vlen[isd_pkg::SIZE_W-1:0] - isd_pkg::SIZE_W'(4);
              state_nxt   = isd_pkg::ST_VLEN_B1;
            end
          end
        end
        isd_pkg::ST_VLEN_B1: begin
          emit      = 1'b1;
          e_byte    = cur_id_r[15:8];
          state_nxt = isd_pkg::ST_VLEN_B2;
        end
        isd_pkg::ST_VLEN_B2: begin
          emit      = 1'b1;
          e_byte    = len_lo_r;
          state_nxt = isd_pkg::ST_VLEN_B3;
        end
        isd_pkg::ST_VLEN_B3: begin
          emit      = 1'b1;
          e_byte    = cur_len_r[15:8];
          e_last    = (rem_r == '0);
          state_nxt = (rem_r == '0) ? isd_pkg::ST_ID0 : isd_pkg::ST_BODY;
        end
        isd_pkg::ST_BODY: begin
          if (q_valid) begin
            q_pop     = 1'b1;
            emit      = 1'b1;
            e_byte    = b;
            e_last    = (rem_r == isd_pkg::SIZE_W'(1));
            rem_nxt   = rem_r - 1'b1;
            state_nxt = (rem_r == isd_pkg::SIZE_W'(1)) ? isd_pkg::ST_ID0 : isd_pkg::ST_BODY;
          end
        end
        default: begin
          if (q_valid) begin
            q_pop     = 1'b1;
            id_lo_nxt = b;
            state_nxt = isd_pkg::ST_ID1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isd_pkg::ST_ID0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (can_emit) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_id_r  <= cur_id_nxt;
    id_lo_r   <= id_lo_nxt;
    len_lo_r  <= len_lo_nxt;
    cur_len_r <= cur_len_nxt;
    rem_r     <= rem_nxt;
    size_r    <= size_nxt;
    if (can_emit && emit) begin
      o_kind_r  <= e_kind;
      o_byte_r  <= e_byte;
      o_first_r <= e_first;
      o_last_r  <= e_last;
      o_id_r    <= e_id;
      o_len_r   <= e_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_len_r, o_id_r, o_byte_r};
  assign out_tuser  = {o_first_r, o_kind_r};
  assign out_tlast  = o_last_r;

  // A packet in its body always has at least one byte still to come.
  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isd_pkg::ST_BODY) |-> (rem_r != '0))
    else $error("body state with no bytes remaining");

  // Header follow-up states emit from stored fields and never take a new byte.
  a_no_pop_in_followup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isd_pkg::ST_HDR_HI || state_r == isd_pkg::ST_VLEN_B1 ||
     state_r == isd_pkg::ST_VLEN_B2 || state_r == isd_pkg::ST_VLEN_B3 ||
     state_r == isd_pkg::ST_REHDR) |-> !q_pop)
    else $error("queue popped during header follow-up");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for id_sized_packet_deframer: streams bytes and size table writes
// into the block and compares every result against a cycle-free prediction of the parser.
// Depends on isd_pkg and the RTL of the deframer.
module tb_top;

  localparam int CYCLE_LIMIT = 300000;
  localparam int POOL_SIZE   = 8;

  // One result as the block reports it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] id;
    logic [15:0] len;
  } deframed_t;

  // Where the parser stands in the byte stream.
  typedef enum logic [2:0] {
    AT_ID_LO,
    AT_ID_HI,
    AT_LEN_LO,
    AT_LEN_HI,
    AT_BODY
  } parse_phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  id_sized_packet_deframer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Predicted parser state and size table.
  parse_phase_t    exp_phase;
  logic [7:0]      exp_id_lo;
  logic [15:0]     exp_id;
  logic [7:0]      exp_len_lo;
  logic [15:0]     exp_len;
  logic [isd_pkg::SIZE_W-1:0] exp_left;
  logic [isd_pkg::SIZE_W-1:0] exp_sizes [0:isd_pkg::TABLE_DEPTH-1];

  deframed_t       due_results [$];
  deframed_t       got;
  deframed_t       want;
  int              errors = 0;
  int              cycle_count = 0;
  int              src_idle_pct;
  int              dst_idle_pct;

  // Ids that carry only small sizes, so packets built on them stay short.
  logic [15:0]     short_ids [POOL_SIZE];
  logic [7:0]      hold_hi;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  function automatic void queue_result(logic [1:0] kind, logic [7:0] data, logic first,
                                       logic last, logic [15:0] id, logic [15:0] len);
    deframed_t r;
    r.kind  = kind;
    r.data  = data;
    r.first = first;
    r.last  = last;
    r.id    = id;
    r.len   = len;
    due_results.push_back(r);
  endfunction

  function automatic logic [isd_pkg::SIZE_W-1:0] size_of(logic [15:0] id);
    // Any bit above the table index makes the id unknown.
    if ((id >> isd_pkg::ID_BITS) != 0) return isd_pkg::SIZE_UNKNOWN;
    return exp_sizes[id[isd_pkg::ID_BITS-1:0]];
  endfunction

  // A complete id has arrived: resolve its size and emit what that allows right away.
  function automatic void open_header(logic [15:0] id);
    logic [isd_pkg::SIZE_W-1:0] sz;
    sz        = size_of(id);
    exp_id    = id;
    exp_id_lo = id[7:0];
    if (sz == isd_pkg::SIZE_UNKNOWN) begin
      queue_result(isd_pkg::KIND_UNKNOWN, 8'h00, 1'b0, 1'b0, id, 16'h0000);
      exp_phase = AT_ID_LO;
    end else if (sz == isd_pkg::SIZE_VARIABLE) begin
      exp_phase = AT_LEN_LO;
    end else begin
      exp_len = {1'b0, sz};
      queue_result(isd_pkg::KIND_BYTE, id[7:0], 1'b1, 1'b0, id, exp_len);
      queue_result(isd_pkg::KIND_BYTE, id[15:8], 1'b0, sz == 2, id, exp_len);
      exp_left  = sz - isd_pkg::SIZE_W'(2);
      exp_phase = (exp_left != 0) ? AT_BODY : AT_ID_LO;
    end
  endfunction

  function automatic void deframe(logic op, logic [7:0] b, logic [11:0] idx,
                                  logic [isd_pkg::SIZE_W-1:0] sz);
    logic [15:0] len;
    if (op == isd_pkg::OP_WRITE) begin
      exp_sizes[idx[isd_pkg::ID_BITS-1:0]] = sz;
      return;
    end
    case (exp_phase)
      AT_ID_HI: begin
        open_header({b, exp_id_lo});
      end
      AT_LEN_LO: begin
        exp_len_lo = b;
        exp_phase  = AT_LEN_HI;
      end
      AT_LEN_HI: begin
        len = {b, exp_len_lo};
        if (len < 4 || len > isd_pkg::MAX_LEN) begin
          // Only the id is dropped; the length bytes become the next id.
          queue_result(isd_pkg::KIND_BADLEN, 8'h00, 1'b0, 1'b0, exp_id, len);
          open_header(len);
        end else begin
          exp_len = len;
          queue_result(isd_pkg::KIND_BYTE, exp_id[7:0], 1'b1, 1'b0, exp_id, len);
          queue_result(isd_pkg::KIND_BYTE, exp_id[15:8], 1'b0, 1'b0, exp_id, len);
          queue_result(isd_pkg::KIND_BYTE, exp_len_lo, 1'b0, 1'b0, exp_id, len);
          queue_result(isd_pkg::KIND_BYTE, b, 1'b0, len == 4, exp_id, len);
          exp_left  = len[isd_pkg::SIZE_W-1:0] - isd_pkg::SIZE_W'(4);
          exp_phase = (exp_left != 0) ? AT_BODY : AT_ID_LO;
        end
      end
      AT_BODY: begin
        exp_left = exp_left - isd_pkg::SIZE_W'(1);
        queue_result(isd_pkg::KIND_BYTE, b, 1'b0, exp_left == 0, exp_id, exp_len);
        if (exp_left == 0) exp_phase = AT_ID_LO;
      end
      default: begin
        exp_id_lo = b;
        exp_phase = AT_ID_HI;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------------------

  // Offers one request, possibly after an idle gap, and predicts it once it is taken.
  // Called and returning just after a rising edge.
  task automatic send_request(input logic op, input logic [7:0] b, input logic [11:0] idx,
                              input logic [isd_pkg::SIZE_W-1:0] sz);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, sz, idx, b};
    do @(posedge clk); while (!in_tready);
    deframe(op, b, idx, sz);
  endtask

  // The table fields of a stream byte are ignored, so they carry random junk.
  task automatic send_byte(input logic [7:0] b);
    send_request(isd_pkg::OP_BYTE, b, 12'($urandom), isd_pkg::SIZE_W'($urandom));
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
  endtask

  task automatic write_size(input logic [11:0] idx, input logic [isd_pkg::SIZE_W-1:0] sz);
    send_request(isd_pkg::OP_WRITE, 8'($urandom), idx, sz);
  endtask

  function automatic logic is_short_id(logic [15:0] id);
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (short_ids[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  task automatic check_field(input string what, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, expv, actv);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.kind  = out_tuser[1:0];
      got.first = out_tuser[2];
      got.last  = out_tlast;
      got.data  = out_tdata[7:0];
      got.id    = out_tdata[23:8];
      got.len   = out_tdata[39:24];
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("byte", want.data, got.data);
        check_field("first", want.first, got.first);
        check_field("last", want.last, got.last);
        check_field("packet_id", want.id, got.id);
        check_field("packet_length", want.len, got.len);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Shortest fixed packet (id bytes only) and a short fixed one with extreme body bytes.
  task automatic test_fixed_packets();
    write_size(12'h001, 15'd2);
    write_size(12'h002, 15'd5);
    write_size(12'h003, isd_pkg::SIZE_VARIABLE);
    send_word(16'h0001);
    send_word(16'h0002);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
  endtask

  // One id beyond the table and one inside it whose entry is still zero.
  task automatic test_unknown_ids();
    send_word(16'hF123);
    send_word(16'h0ABC);
  endtask

  // Shortest valid variable length, then bad lengths that re-parse as a variable id,
  // as an id beyond the table and as a fixed id.
  task automatic test_variable_lengths();
    send_word(16'h0003);
    send_word(16'h0004);
    send_word(16'h0003);
    send_word(16'h0003);
    send_word(16'h8000);
    send_word(16'h0003);
    send_word(16'h0001);
  endtask

  // A table write between the two id bytes applies to the lookup of that very id.
  task automatic test_write_mid_header();
    send_byte(8'h02);
    write_size(12'h002, 15'd3);
    send_byte(8'h00);
    send_byte(8'hC3);
  endtask

  // Pick the short ids and load the four random ones with small sizes before the random stream starts.
  task automatic test_short_id_setup();
    for (int i = 0; i < POOL_SIZE; i++) begin
      short_ids[i] = (i < 4) ? 16'(i) : 16'($urandom_range(4, 4094));
    end
    for (int i = 4; i < POOL_SIZE; i++) begin
      write_size(short_ids[i][11:0], isd_pkg::SIZE_W'($urandom_range(0, 14)));
    end
  endtask

  // Mostly well-formed packets with random content, steered by the predicted parser
  // phase; the rest is unknown ids, bad lengths and table writes at any point.
  // Between the id bytes only small sizes are written, so a pending id never turns long.
  task automatic test_random_stream(input int n_bytes);
    int          sent;
    logic [15:0] w;
    logic [11:0] idx;
    sent = 0;
    while (sent < n_bytes || exp_phase != AT_ID_LO) begin
      if ($urandom_range(0, 99) < 8) begin
        idx = 12'($urandom);
        if (idx < 4 || is_short_id({4'h0, idx}) || exp_phase == AT_ID_HI)
          write_size(idx, isd_pkg::SIZE_W'($urandom_range(0, 14)));
        else
          write_size(idx, isd_pkg::SIZE_W'($urandom));
      end else begin
        case (exp_phase)
          AT_ID_LO: begin
            if ($urandom_range(0, 99) < 75) begin
              w = short_ids[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
              do w = 16'($urandom); while (size_of(w) != isd_pkg::SIZE_UNKNOWN);
            end
            hold_hi = w[15:8];
            send_byte(w[7:0]);
          end
          AT_LEN_LO: begin
            if ($urandom_range(0, 99) < 80)
              w = 16'($urandom_range(4, 16));
            else if ($urandom_range(0, 1) == 0)
              w = 16'($urandom_range(0, 3));
            else
              w = 16'($urandom_range(16'h8000, 16'hFFFF));
            hold_hi = w[15:8];
            send_byte(w[7:0]);
          end
          AT_ID_HI, AT_LEN_HI: begin
            send_byte(hold_hi);
          end
          default: begin
            send_byte(8'($urandom));
          end
        endcase
        sent++;
      end
    end
  endtask

  // The largest fixed size, at the top of the table: its header and the first body bytes.
  task automatic test_longest_packet();
    write_size(12'hFFF, isd_pkg::MAX_LEN);
    send_word(16'h0FFF);
    repeat (6) send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    src_idle_pct = 13;
    dst_idle_pct = 85;
    exp_phase    = AT_ID_LO;
    exp_id_lo    = '0;
    exp_id       = '0;
    exp_len_lo   = '0;
    exp_len      = '0;
    exp_left     = '0;
    hold_hi      = '0;
    for (int i = 0; i < isd_pkg::TABLE_DEPTH; i++) exp_sizes[i] = isd_pkg::SIZE_UNKNOWN;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= isd_pkg::OP_BYTE;
    in_tdata   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears its table after reset; the first request simply waits for it.
    test_fixed_packets();
    test_unknown_ids();
    test_variable_lengths();
    test_write_mid_header();
    test_short_id_setup();
    test_random_stream(40);

    src_idle_pct = 85;
    dst_idle_pct = 13;
    test_random_stream(40);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_random_stream(40);
    test_longest_packet();

    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/isd_pkg.sv
design/isd_front.sv
design/isd_queue.sv
design/isd_back.sv
design/id_sized_packet_deframer.sv
test/tb_top.sv
